FILE: sv/gmd_pkg.sv
package gmd_pkg;

  // Default grid and stack sizes.
  localparam int GRID_ROWS_DEF   = 16;
  localparam int GRID_COLS_DEF   = 16;
  localparam int STACK_DEPTH_DEF = 256;

  // Fixed field widths.
  localparam int COORD_W    = 4;
  localparam int PATH_IDX_W = 8;
  localparam int PATH_LEN_W = 9;
  localparam int CELL_W     = 2;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL  = 2'd3;

  // Configuration reset values.
  localparam logic [COORD_W-1:0] START_ROW_RST = 4'd1;
  localparam logic [COORD_W-1:0] START_COL_RST = 4'd1;
  localparam logic [COORD_W-1:0] GOAL_ROW_RST  = 4'd7;
  localparam logic [COORD_W-1:0] GOAL_COL_RST  = 4'd8;

  // Cell codes.
  localparam logic [CELL_W-1:0] CELL_WALL = 2'd0;
  localparam logic [CELL_W-1:0] CELL_OPEN = 2'd1;
  localparam logic [CELL_W-1:0] CELL_SEEN = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_SEARCH    = 2'd1,
    OP_READ_PATH = 2'd2,
    OP_READ_CELL = 2'd3
  } op_e;

  // Direction tried last for a stack entry, in search order.
  typedef enum logic [DIR_W-1:0] {
    DIR_EAST  = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_WEST  = 2'd2,
    DIR_NORTH = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OP,
    ST_CHECK,
    ST_CHECK_RD,
    ST_BACK,
    ST_POP
  } state_e;

  typedef struct packed {
    op_e                   opcode;
    logic [COORD_W-1:0]    cell_row;
    logic [COORD_W-1:0]    cell_col;
    logic                  cell_open;
    logic [PATH_IDX_W-1:0] path_index;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [PATH_LEN_W-1:0] path_length;
    logic [COORD_W-1:0]    entry_row;
    logic [COORD_W-1:0]    entry_col;
    logic [CELL_W-1:0]     cell_state;
  } rsp_t;

endpackage

FILE: sv/grid_maze_dfs_path_search_top.sv
// Channel    Handshake             Payload        Direction
// request    start / busy          req_i (req_t)  in
// result     result_valid_o        rsp_o (rsp_t)  out
// config     cfg_we_i              cfg_idx_i,     in
//                                  cfg_data_i
//
// A request is taken at a rising edge with start high and busy low. Cell writes, cell reads
// and path reads pass through the ST_OP state and then the registered result strobe, with
// busy high until then; the next request may be taken in the cycle the result is shown.
// A search probes each neighbor in ST_CHECK (address) and then in ST_CHECK_RD (cell read;
// the push happens in the read state); a probe outside the grid goes from ST_CHECK straight
// to ST_BACK. A backtrack passes ST_BACK, then stays in ST_POP for each exhausted stack
// entry it drops; the single read port of the cell and of the stack memory sets this order.
// After reset the cell memory, 2**(row bits + column bits) cells (256 at the default size),
// is cleared one cell a cycle with busy high; configuration writes are taken meanwhile.
// The receiver cannot stall: each result is shown for exactly one cycle.
module grid_maze_dfs_path_search_top #(
  parameter int GRID_ROWS   = gmd_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS   = gmd_pkg::GRID_COLS_DEF,
  parameter int STACK_DEPTH = gmd_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  gmd_pkg::req_t                  req_i,
  output logic                           busy,
  output logic                           result_valid_o,
  output gmd_pkg::rsp_t                  rsp_o,
  input  logic                           cfg_we_i,
  input  logic [gmd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gmd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import gmd_pkg::*;

  // Address bits of a row and a column; a cell's address is {row, column}.
  localparam int RW  = $clog2(GRID_ROWS);
  localparam int CW  = $clog2(GRID_COLS);
  localparam int AW  = RW + CW;
  // Search coordinates carry one extra bit so that a step off either edge of the grid
  // lands on a value at or above the grid size.
  localparam int XR  = ((RW > COORD_W) ? RW : COORD_W) + 1;
  localparam int XC  = ((CW > COORD_W) ? CW : COORD_W) + 1;
  // Stack address, stack pointer and entry widths.
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int EW  = RW + CW + DIR_W;
  localparam int IW  = (SPW > PATH_IDX_W) ? SPW : PATH_IDX_W;

  state_e state_q, state_d;

  logic [AW-1:0]      clr_q, clr_d;
  logic [SPW-1:0]     sp_q, sp_d;
  logic               found_q, found_d;
  logic               rvalid_q, rvalid_d;
  logic [COORD_W-1:0] start_row_q, start_col_q, goal_row_q, goal_col_q;

  logic [XR-1:0] cur_r_q, cur_r_d;
  logic [XC-1:0] cur_c_q, cur_c_d;
  op_e           op_q, op_d;
  logic          hit_q, hit_d;
  rsp_t          rsp_q, rsp_d;

  // Memory ports.
  logic              cell_we, cell_re;
  logic [AW-1:0]     cell_waddr, cell_raddr;
  logic [CELL_W-1:0] cell_wdata, cell_rdata;
  logic              stk_we, stk_re;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  logic [EW-1:0]     stk_wdata, stk_rdata;

  // Decoded conditions shared by the next-state and datapath logic.
  logic [XR-1:0]    req_r;
  logic [XC-1:0]    req_c;
  logic             req_in_grid;
  logic [AW-1:0]    req_addr, cur_addr;
  logic             cur_in_grid, can_probe, cell_is_open, at_goal, sp_zero, pop_north;
  logic [SPW-1:0]   sp_dec;
  logic [RW-1:0]    pop_row;
  logic [CW-1:0]    pop_col;
  logic [DIR_W-1:0] pop_dir, next_dir;
  logic             finish;

  assign req_r       = XR'(req_i.cell_row);
  assign req_c       = XC'(req_i.cell_col);
  assign req_in_grid = (req_r < XR'(GRID_ROWS)) && (req_c < XC'(GRID_COLS));
  assign req_addr    = {req_r[RW-1:0], req_c[CW-1:0]};

  assign cur_addr     = {cur_r_q[RW-1:0], cur_c_q[CW-1:0]};
  assign cur_in_grid  = (cur_r_q < XR'(GRID_ROWS)) && (cur_c_q < XC'(GRID_COLS));
  // A full stack makes the probed cell behave like a wall.
  assign can_probe    = cur_in_grid && (sp_q < SPW'(STACK_DEPTH));
  assign cell_is_open = (cell_rdata == CELL_OPEN);
  assign at_goal      = (cur_r_q == XR'(goal_row_q)) && (cur_c_q == XC'(goal_col_q));
  assign sp_zero      = (sp_q == '0);
  assign sp_dec       = sp_q - SPW'(1);

  assign pop_row   = stk_rdata[EW-1 -: RW];
  assign pop_col   = stk_rdata[CW+DIR_W-1 -: CW];
  assign pop_dir   = stk_rdata[DIR_W-1:0];
  assign pop_north = (pop_dir == DIR_NORTH);
  assign next_dir  = pop_dir + DIR_W'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = (req_i.opcode == OP_SEARCH) ? ST_CHECK : ST_OP;
        end
      end
      ST_OP: begin
        state_d = ST_IDLE;
      end
      ST_CHECK: begin
        state_d = can_probe ? ST_CHECK_RD : ST_BACK;
      end
      ST_CHECK_RD: begin
        if (cell_is_open) begin
          state_d = at_goal ? ST_IDLE : ST_CHECK;
        end else begin
          state_d = ST_BACK;
        end
      end
      ST_BACK: begin
        state_d = sp_zero ? ST_IDLE : ST_POP;
      end
      ST_POP: begin
        if (pop_north) begin
          state_d = sp_zero ? ST_IDLE : ST_POP;
        end else begin
          state_d = ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory controls and register updates.
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = cur_addr;
    cell_wdata = CELL_WALL;
    cell_re    = 1'b0;
    cell_raddr = cur_addr;
    stk_we     = 1'b0;
    stk_waddr  = SAW'(sp_q);
    stk_wdata  = '0;
    stk_re     = 1'b0;
    stk_raddr  = SAW'(sp_dec);
    clr_d      = clr_q;
    sp_d       = sp_q;
    found_d    = found_q;
    cur_r_d    = cur_r_q;
    cur_c_d    = cur_c_q;
    op_d       = op_q;
    hit_d      = hit_q;
    rsp_d      = rsp_q;
    rvalid_d   = 1'b0;
    finish     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_q;
        clr_d      = clr_q + AW'(1);
      end
      ST_IDLE: begin
        if (start) begin
          op_d = req_i.opcode;
          unique case (req_i.opcode)
            OP_WRITE: begin
              cell_we    = req_in_grid;
              cell_waddr = req_addr;
              cell_wdata = req_i.cell_open ? CELL_OPEN : CELL_WALL;
            end
            OP_SEARCH: begin
              sp_d    = '0;
              found_d = 1'b0;
              cur_r_d = XR'(start_row_q);
              cur_c_d = XC'(start_col_q);
            end
            OP_READ_PATH: begin
              stk_re    = 1'b1;
              stk_raddr = SAW'(req_i.path_index);
              hit_d     = IW'(req_i.path_index) < IW'(sp_q);
            end
            OP_READ_CELL: begin
              cell_re    = 1'b1;
              cell_raddr = req_addr;
              hit_d      = req_in_grid;
            end
          endcase
        end
      end
      ST_OP: begin
        rvalid_d          = 1'b1;
        rsp_d.found       = found_q;
        rsp_d.path_length = PATH_LEN_W'(sp_q);
        rsp_d.entry_row   = '0;
        rsp_d.entry_col   = '0;
        rsp_d.cell_state  = CELL_WALL;
        if (op_q == OP_READ_PATH && hit_q) begin
          rsp_d.entry_row = COORD_W'(pop_row);
          rsp_d.entry_col = COORD_W'(pop_col);
        end
        if (op_q == OP_READ_CELL && hit_q) begin
          rsp_d.cell_state = cell_rdata;
        end
      end
      ST_CHECK: begin
        cell_re = can_probe;
      end
      ST_CHECK_RD: begin
        if (cell_is_open) begin
          cell_we    = 1'b1;
          cell_wdata = CELL_SEEN;
          stk_we     = 1'b1;
          stk_wdata  = {cur_r_q[RW-1:0], cur_c_q[CW-1:0], DIR_EAST};
          sp_d       = sp_q + SPW'(1);
          if (at_goal) begin
            found_d = 1'b1;
            finish  = 1'b1;
          end else begin
            cur_c_d = cur_c_q + XC'(1);
          end
        end
      end
      ST_BACK: begin
        if (sp_zero) begin
          finish = 1'b1;
        end else begin
          stk_re = 1'b1;
          sp_d   = sp_dec;
        end
      end
      ST_POP: begin
        if (pop_north) begin
          // Every direction of this entry is spent: drop it and look one further down.
          if (sp_zero) begin
            finish = 1'b1;
          end else begin
            stk_re = 1'b1;
            sp_d   = sp_dec;
          end
        end else begin
          stk_we    = 1'b1;
          stk_wdata = {pop_row, pop_col, next_dir};
          sp_d      = sp_q + SPW'(1);
          cur_r_d   = XR'(pop_row);
          cur_c_d   = XC'(pop_col);
          unique case (dir_e'(next_dir))
            DIR_EAST:  cur_c_d = XC'(pop_col) + XC'(1);
            DIR_SOUTH: cur_r_d = XR'(pop_row) + XR'(1);
            DIR_WEST:  cur_c_d = XC'(pop_col) - XC'(1);
            DIR_NORTH: cur_r_d = XR'(pop_row) - XR'(1);
          endcase
        end
      end
      default: begin
        clr_d = '0;
      end
    endcase

    if (finish) begin
      rvalid_d          = 1'b1;
      rsp_d.found       = found_d;
      rsp_d.path_length = PATH_LEN_W'(sp_d);
      rsp_d.entry_row   = '0;
      rsp_d.entry_col   = '0;
      rsp_d.cell_state  = CELL_WALL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      sp_q     <= '0;
      found_q  <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      sp_q     <= sp_d;
      found_q  <= found_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_row_q <= START_ROW_RST;
      start_col_q <= START_COL_RST;
      goal_row_q  <= GOAL_ROW_RST;
      goal_col_q  <= GOAL_COL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_ROW: start_row_q <= cfg_data_i;
        CFG_START_COL: start_col_q <= cfg_data_i;
        CFG_GOAL_ROW:  goal_row_q  <= cfg_data_i;
        CFG_GOAL_COL:  goal_col_q  <= cfg_data_i;
      endcase
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    cur_r_q <= cur_r_d;
    cur_c_q <= cur_c_d;
    op_q    <= op_d;
    hit_q   <= hit_d;
    rsp_q   <= rsp_d;
  end

  // Cell states: wall, open or visited.
  gmd_ram #(
    .DATA_W (CELL_W),
    .ADDR_W (AW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (cell_re),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  // Backtracking stack: row, column and the direction tried last.
  gmd_ram #(
    .DATA_W (EW),
    .ADDR_W (SAW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = rvalid_q;
  assign rsp_o          = rsp_q;

endmodule

FILE: sv/gmd_ram.sv
module gmd_ram #(
  parameter int DATA_W = 2,
  parameter int ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the output holds its value while re_i is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: sv/gmd_checker.sv
module gmd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          result_valid_o,
  input gmd_pkg::rsp_t rsp_o
);

  import gmd_pkg::*;

  // A taken request always turns the block busy in the cycle after it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken without the block turning busy");

  // A result is shown only once the block is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  // Each request gives one result, never two in a row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // A result always follows work: the block was busy in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without preceding work");

  // The cell memory holds only wall, open or visited codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rsp_o.cell_state == CELL_WALL || rsp_o.cell_state == CELL_OPEN ||
                        rsp_o.cell_state == CELL_SEEN))
    else $error("illegal cell state returned");

endmodule

bind grid_maze_dfs_path_search_top gmd_checker u_gmd_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import gmd_pkg::*;

  localparam int ROWS  = GRID_ROWS_DEF;
  localparam int COLS  = GRID_COLS_DEF;
  localparam int DEPTH = STACK_DEPTH_DEF;

  // The longest quiet stretch of a correct run is one search over a fully open grid; the
  // limit is set well above it.
  localparam int QUIET_LIMIT = 40000;

  // A request is either idle on the bus or waits for busy to drop. This target is roughly
  // how many requests the run sends.
  localparam int REQUEST_TARGET = 1800;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // The request side starts out idle, and so does the register port.
  logic                  start_q  = 1'b0;
  req_t                  req_q    = '0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic busy;
  logic answer_valid;
  rsp_t answer;

  always #10 clk_i = ~clk_i;

  grid_maze_dfs_path_search_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start_q),
    .req_i         (req_q),
    .busy          (busy),
    .result_valid_o(answer_valid),
    .rsp_o         (answer),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  // Requests waiting to go out, and the answers the block still owes, oldest first.
  req_t pending_reqs [$];
  rsp_t owed_answers [$];

  int idle_pct     = 34;
  int issued       = 0;
  int n_accepted   = 0;
  int n_checked    = 0;
  int mismatches   = 0;
  int n_searches   = 0;
  int n_found      = 0;
  int longest_path = 0;

  // Our own copy of the maze: the cell memory, the backtracking trail, the result of the
  // last search, and the start and goal registers.
  logic [CELL_W-1:0]  maze_cells [ROWS*COLS];
  int                 trail_row  [DEPTH];
  int                 trail_col  [DEPTH];
  dir_e               trail_dir  [DEPTH];
  int                 trail_len    = 0;
  bit                 goal_reached = 1'b0;
  logic [COORD_W-1:0] origin_row   = START_ROW_RST;
  logic [COORD_W-1:0] origin_col   = START_COL_RST;
  logic [COORD_W-1:0] target_row   = GOAL_ROW_RST;
  logic [COORD_W-1:0] target_col   = GOAL_COL_RST;

  initial begin
    foreach (maze_cells[i]) maze_cells[i] = CELL_WALL;
  end

  // Anything outside the grid reads as a wall.
  function automatic logic [CELL_W-1:0] cell_value(int r, int c);
    if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return CELL_WALL;
    return maze_cells[r*COLS + c];
  endfunction

  function automatic void move_toward(dir_e d, inout int r, inout int c);
    case (d)
      DIR_EAST:  c++;
      DIR_SOUTH: r++;
      DIR_WEST:  c--;
      default:   r--;
    endcase
  endfunction

  // Depth-first walk from the start cell. Each trail entry remembers the last direction
  // tried from it; a backtrack moves the top entry on to its next direction and drops
  // every entry that has already tried north.
  function automatic void dfs_walk();
    int   r;
    int   c;
    dir_e d;
    bit   done;
    r            = int'(origin_row);
    c            = int'(origin_col);
    trail_len    = 0;
    goal_reached = 1'b0;
    done         = 1'b0;
    while (!done) begin
      if (cell_value(r, c) == CELL_OPEN && trail_len < DEPTH) begin
        maze_cells[r*COLS + c] = CELL_SEEN;
        trail_row[trail_len]   = r;
        trail_col[trail_len]   = c;
        trail_dir[trail_len]   = DIR_EAST;
        trail_len++;
        if (r == int'(target_row) && c == int'(target_col)) begin
          goal_reached = 1'b1;
          done         = 1'b1;
        end else begin
          move_toward(DIR_EAST, r, c);
        end
      end else if (trail_len == 0) begin
        done = 1'b1;
      end else begin
        trail_len--;
        d = trail_dir[trail_len];
        while (d == DIR_NORTH && trail_len > 0) begin
          trail_len--;
          d = trail_dir[trail_len];
        end
        if (d == DIR_NORTH) begin
          done = 1'b1;
        end else begin
          d                    = dir_e'(d + 1);
          trail_dir[trail_len] = d;
          r                    = trail_row[trail_len];
          c                    = trail_col[trail_len];
          trail_len++;
          move_toward(d, r, c);
        end
      end
    end
  endfunction

  // Applies one accepted request to our copy of the maze and returns the answer it owes.
  function automatic rsp_t compute_maze_answer(req_t rq);
    rsp_t a;
    int   r;
    int   c;
    a = '0;
    r = int'(rq.cell_row);
    c = int'(rq.cell_col);
    case (rq.opcode)
      OP_WRITE: begin
        if (r < ROWS && c < COLS) maze_cells[r*COLS + c] = rq.cell_open ? CELL_OPEN : CELL_WALL;
      end
      OP_SEARCH: begin
        dfs_walk();
        n_searches++;
        if (goal_reached) n_found++;
        if (trail_len > longest_path) longest_path = trail_len;
      end
      OP_READ_PATH: begin
        if (int'(rq.path_index) < trail_len) begin
          a.entry_row = COORD_W'(trail_row[rq.path_index]);
          a.entry_col = COORD_W'(trail_col[rq.path_index]);
        end
      end
      default: a.cell_state = cell_value(r, c);
    endcase
    a.found       = goal_reached;
    a.path_length = PATH_LEN_W'(trail_len);
    return a;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Request driver. The request on the bus stays there until the block takes it; after a
  // take, the next pending request goes out unless this cycle is picked as an idle one.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    if (!rst_ni) begin
      start_q <= 1'b0;
      req_q   <= '0;
    end else begin
      if (start_q && !busy) begin
        owed_answers.push_back(compute_maze_answer(req_q));
        n_accepted++;
      end
      if (!(start_q && busy)) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start_q <= 1'b1;
          req_q   <= pending_reqs.pop_front();
        end else begin
          start_q <= 1'b0;
        end
      end
    end
  end

  // Answer monitor. Every strobed answer is held against the oldest owed one, field by
  // field.
  always @(posedge clk_i) begin : check_answers
    rsp_t want;
    if (rst_ni && answer_valid) begin
      if (owed_answers.size() == 0) begin
        flag_mismatch("answer with no request outstanding", 1, 0);
      end else begin
        want = owed_answers.pop_front();
        n_checked++;
        if (answer.found != want.found)
          flag_mismatch("found", int'(answer.found), int'(want.found));
        if (answer.path_length != want.path_length)
          flag_mismatch("path_length", int'(answer.path_length), int'(want.path_length));
        if (answer.entry_row != want.entry_row)
          flag_mismatch("entry_row", int'(answer.entry_row), int'(want.entry_row));
        if (answer.entry_col != want.entry_col)
          flag_mismatch("entry_col", int'(answer.entry_col), int'(want.entry_col));
        if (answer.cell_state != want.cell_state)
          flag_mismatch("cell_state", int'(answer.cell_state), int'(want.cell_state));
      end
    end
  end

  // Watchdog: a run in which neither a request nor an answer moves for too long has hung.
  always @(posedge clk_i) begin : watchdog
    int quiet_cycles;
    if ((start_q && !busy) || answer_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles, %0d answers still owed", $time,
                 QUIET_LIMIT, owed_answers.size());
        $display("grid_maze_dfs_path_search_top verification failed");
        $finish;
      end
    end
  end

  function automatic void queue_request(op_e op, int r, int c, bit open, int idx);
    req_t rq;
    rq.opcode     = op;
    rq.cell_row   = COORD_W'(r);
    rq.cell_col   = COORD_W'(c);
    rq.cell_open  = open;
    rq.path_index = PATH_IDX_W'(idx);
    pending_reqs.push_back(rq);
    issued++;
  endfunction

  // Returns at a falling edge once every request has gone out and been answered.
  task automatic wait_until_settled();
    while (pending_reqs.size() != 0 || start_q || owed_answers.size() != 0) @(negedge clk_i);
  endtask

  // Rewrites all four endpoint registers. Only called with the block idle.
  task automatic program_endpoints(int sr, int sc, int gr, int gc);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_START_ROW, CFG_START_COL, CFG_GOAL_ROW, CFG_GOAL_COL};
    val = '{CFG_DATA_W'(sr), CFG_DATA_W'(sc), CFG_DATA_W'(gr), CFG_DATA_W'(gc)};
    wait_until_settled();
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= val[i];
    end
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    origin_row = COORD_W'(sr);
    origin_col = COORD_W'(sc);
    target_row = COORD_W'(gr);
    target_col = COORD_W'(gc);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int r0;
    int c0;
    int h;
    int w;
    int sr;
    int sc;
    int gr;
    int gc;
    int n;
    int full_grids;
    bit open;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset endpoints, start (1,1) and goal (7,8). A search over the all-wall grid fails at
    // once, and so does a search whose start cell was already visited. Reads hit two opposite
    // grid corners and the top end of the path index range.
    queue_request(OP_SEARCH, 0, 0, 1'b0, 0);
    queue_request(OP_READ_CELL, 0, 0, 1'b1, 255);
    queue_request(OP_READ_CELL, 15, 15, 1'b0, 0);
    queue_request(OP_READ_PATH, 15, 15, 1'b1, 255);
    queue_request(OP_WRITE, 1, 1, 1'b1, 255);
    queue_request(OP_WRITE, 15, 15, 1'b1, 0);
    queue_request(OP_WRITE, 15, 15, 1'b0, 255);
    queue_request(OP_READ_CELL, 15, 15, 1'b1, 0);
    queue_request(OP_SEARCH, 15, 0, 1'b1, 128);
    queue_request(OP_READ_CELL, 1, 1, 1'b0, 0);
    queue_request(OP_SEARCH, 0, 15, 1'b0, 1);

    // Start and goal are the same corner cell, whose east and south neighbors lie outside
    // the grid: a one-cell path.
    program_endpoints(15, 15, 15, 15);
    queue_request(OP_WRITE, 15, 15, 1'b1, 0);
    queue_request(OP_SEARCH, 0, 0, 1'b0, 0);
    queue_request(OP_READ_PATH, 0, 0, 1'b0, 0);
    queue_request(OP_READ_PATH, 0, 0, 1'b0, 1);

    // A small maze from (0,0) to (0,2) with a dead end at (1,3): the walk goes south, east,
    // backs out of the dead end and finishes going north.
    program_endpoints(0, 0, 0, 2);
    queue_request(OP_WRITE, 0, 0, 1'b1, 7);
    queue_request(OP_WRITE, 1, 0, 1'b1, 9);
    queue_request(OP_WRITE, 1, 1, 1'b1, 11);
    queue_request(OP_WRITE, 1, 2, 1'b1, 13);
    queue_request(OP_WRITE, 1, 3, 1'b1, 17);
    queue_request(OP_WRITE, 0, 2, 1'b1, 19);
    queue_request(OP_SEARCH, 3, 3, 1'b0, 0);
    queue_request(OP_READ_PATH, 0, 0, 1'b1, 0);
    queue_request(OP_READ_PATH, 0, 0, 1'b1, 1);
    queue_request(OP_READ_PATH, 0, 0, 1'b1, 4);
    queue_request(OP_READ_PATH, 0, 0, 1'b1, 5);

    // Random episodes: carve a random box of the grid into open cells and walls, place the
    // start and the goal, search, then read the whole path back and sample cells. A few
    // episodes carve the full grid; a stray request now and then adds noise.
    full_grids = 0;
    while (issued < REQUEST_TARGET) begin
      if ($urandom_range(11) == 0 && full_grids < 4) begin
        h = ROWS;
        w = COLS;
        full_grids++;
      end else begin
        h = $urandom_range(7, 2);
        w = $urandom_range(7, 2);
      end
      r0 = $urandom_range(ROWS - h);
      c0 = $urandom_range(COLS - w);
      if ($urandom_range(3) == 0) r0 = $urandom_range(1) ? ROWS - h : 0;
      if ($urandom_range(3) == 0) c0 = $urandom_range(1) ? COLS - w : 0;
      sr = r0 + $urandom_range(h - 1);
      sc = c0 + $urandom_range(w - 1);
      gr = r0 + $urandom_range(h - 1);
      gc = c0 + $urandom_range(w - 1);
      if ($urandom_range(9) == 0) begin
        gr = sr;
        gc = sc;
      end else if ($urandom_range(9) == 0) begin
        gr = $urandom_range(ROWS - 1);
        gc = $urandom_range(COLS - 1);
      end
      program_endpoints(sr, sc, gr, gc);

      // A stretch in the middle of the run presents requests back to back.
      idle_pct = (issued > 700 && issued < 1000) ? 0 : 34;

      for (int r = r0; r < r0 + h; r++) begin
        for (int c = c0; c < c0 + w; c++) begin
          open = ($urandom_range(99) < 72);
          if ((r == sr && c == sc) || (r == gr && c == gc)) open = ($urandom_range(19) != 0);
          queue_request(OP_WRITE, r, c, open, $urandom_range(255));
          if ($urandom_range(99) < 6) begin
            queue_request(op_e'($urandom_range(3)), $urandom_range(ROWS - 1),
                          $urandom_range(COLS - 1), 1'($urandom_range(1)),
                          $urandom_range(255));
          end
        end
      end
      queue_request(OP_SEARCH, $urandom_range(15), $urandom_range(15), 1'($urandom_range(1)),
                    $urandom_range(255));
      if ($urandom_range(6) == 0) begin
        queue_request(OP_SEARCH, $urandom_range(15), $urandom_range(15),
                      1'($urandom_range(1)), $urandom_range(255));
      end

      // The path length is known once the search has been taken.
      wait_until_settled();
      n = trail_len;
      for (int k = 0; k <= n; k++) begin
        queue_request(OP_READ_PATH, $urandom_range(15), $urandom_range(15),
                      1'($urandom_range(1)), k);
      end
      queue_request(OP_READ_PATH, $urandom_range(15), $urandom_range(15),
                    1'($urandom_range(1)), $urandom_range(255));
      repeat ($urandom_range(8, 3)) begin
        queue_request(OP_READ_CELL, r0 + $urandom_range(h - 1), c0 + $urandom_range(w - 1),
                      1'($urandom_range(1)), $urandom_range(255));
      end
    end

    wait_until_settled();
    repeat (10) @(posedge clk_i);

    $display("%0d requests answered and checked; %0d searches, %0d of them reached the goal",
             n_checked, n_searches, n_found);
    $display("longest path found: %0d cells; %0d mismatches", longest_path, mismatches);
    if (mismatches == 0) begin
      $display("grid_maze_dfs_path_search_top verification clean");
    end else begin
      $display("grid_maze_dfs_path_search_top verification failed");
    end
    $finish;
  end

endmodule
